[sv/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned T_W = 25;     // 2*N + bias, N <= 255^3
  localparam int unsigned PROD_W = 42;  // T_W + 17 bit reciprocal

  localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [T_W-1:0] ROUND_BIAS = 25'd65025;     // 255*255
  localparam logic [T_W-1:0] DIVISOR = 25'd130050;       // 2*255*255
  localparam logic [16:0] RECIP = 17'd66051;             // floor(2^33 / 130050)
  localparam int unsigned RECIP_SHIFT = 33;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] brightness;
  } hsv_pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_pixel_t;

  typedef struct packed {
    logic [2:0]      sext;
    logic [CH_W-1:0] k;
    logic [15:0]     vs;
    logic [15:0]     vp;
    logic [CH_W-1:0] chroma;
  } front_t;

  typedef struct packed {
    logic [2:0]      sext;
    logic [CH_W-1:0] chroma;
    logic [T_W-1:0]  tx;
    logic [T_W-1:0]  tb;
  } mix_t;

endpackage

[sv/hsv2rgb_front.sv]
module hsv2rgb_front
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  hsv_pixel_t pix,
  output front_t     st
);

  front_t st_next;
  logic [10:0] h6;
  logic [10:0] rem;
  logic [2:0] sext;
  logic [CH_W-1:0] r8;

  always_comb begin
    h6 = 11'({pix.hue, 2'b00}) + 11'({pix.hue, 1'b0});
    // sextant = number of multiples of 255 not above 6*hue
    sext = 3'd0;
    for (int i = 1; i <= 6; i++) begin
      if (h6 >= 11'(i * 255)) begin
        sext = sext + 3'd1;
      end
    end
    rem = h6 - 11'({sext, 8'h00}) + 11'(sext);
    r8 = rem[7:0];
    st_next.sext = sext;
    st_next.k = sext[0] ? (FULL_SCALE - r8) : r8;
    st_next.vs = 16'(pix.brightness) * 16'(pix.saturation);
    st_next.vp = 16'(pix.brightness) * 16'(FULL_SCALE - pix.saturation);
    st_next.chroma = pix.brightness;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

endmodule

[sv/hsv2rgb_mix.sv]
module hsv2rgb_mix
  import hsv2rgb_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  front_t fr,
  output mix_t   st
);

  mix_t st_next;
  logic [23:0] base;
  logic [23:0] nx;

  always_comb begin
    base = 24'({fr.vp, 8'h00}) - 24'(fr.vp);   // 255 * v * (255 - s)
    nx = 24'(fr.vs) * 24'(fr.k) + base;
    st_next.sext = fr.sext;
    st_next.chroma = fr.chroma;
    st_next.tx = T_W'({nx, 1'b0}) + ROUND_BIAS;
    st_next.tb = T_W'({base, 1'b0}) + ROUND_BIAS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

endmodule

[sv/hsv2rgb_rdiv.sv]
module hsv2rgb_rdiv
  import hsv2rgb_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [T_W-1:0]  t,
  output logic [CH_W-1:0] chan
);

  logic [T_W-1:0] tval;
  logic [PROD_W-1:0] prod;
  logic [8:0] qe;
  logic [T_W:0] rem;
  logic [9:0] qr;

  always_ff @(posedge clk) begin
    if (en) begin
      tval <= t;
      prod <= PROD_W'(t) * PROD_W'(RECIP);
    end
  end

  // reciprocal estimate is exact or one low; one compare fixes it
  always_comb begin
    qe = prod[RECIP_SHIFT +: 9];
    rem = (T_W+1)'(tval) - (T_W+1)'(qe) * (T_W+1)'(DIVISOR);
    qr = 10'(qe) + 10'(rem >= (T_W+1)'(DIVISOR));
    chan = (qr > 10'(FULL_SCALE)) ? FULL_SCALE : qr[CH_W-1:0];
  end

endmodule

[sv/hsv_to_rgb_converter_unit.sv]
// HSV to RGB pixel converter, 8 bits per channel.
//
// Input channel hsv: hue (0..255 around the circle), saturation and
// brightness; transfer when hsv_valid is high and hsv_stall low.
// Output channel rgb: red, green, blue, rounded half up; transfer when
// rgb_valid is high and rgb_stall low.
//
// Four register stages: sextant and 8x8 products, mixed-channel sum,
// reciprocal multiply, then rounding fixup with channel swizzle into the
// output register. One pixel per clock sustained while rgb_stall is low.
//
// Each stage holds its own valid bit and advances when the stage after it
// is empty or moving, so bubbles are squeezed out. With rgb_valid and rgb_stall
// high the output holds; hsv_stall rises only once every stage is full.
// rst (synchronous) empties the pipeline; no state is kept between pixels.
module hsv_to_rgb_converter_unit
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       hsv_valid,
  output logic       hsv_stall,
  input  hsv_pixel_t hsv,
  output logic       rgb_valid,
  input  logic       rgb_stall,
  output rgb_pixel_t rgb
);

  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv4;
  front_t fr;
  mix_t mx;
  logic [2:0] sext;
  logic [CH_W-1:0] chroma;
  logic [CH_W-1:0] xval, mval;
  rgb_pixel_t rgb_next;

  assign adv4 = !rgb_valid || !rgb_stall;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign hsv_stall = !adv1;

  hsv2rgb_front u_front (
    .clk (clk),
    .en  (adv1),
    .pix (hsv),
    .st  (fr)
  );

  hsv2rgb_mix u_mix (
    .clk (clk),
    .en  (adv2),
    .fr  (fr),
    .st  (mx)
  );

  hsv2rgb_rdiv u_div_x (
    .clk  (clk),
    .en   (adv3),
    .t    (mx.tx),
    .chan (xval)
  );

  hsv2rgb_rdiv u_div_m (
    .clk  (clk),
    .en   (adv3),
    .t    (mx.tb),
    .chan (mval)
  );

  always_comb begin
    case (sext)
      3'd0: rgb_next = '{red: chroma, green: xval, blue: mval};
      3'd1: rgb_next = '{red: xval, green: chroma, blue: mval};
      3'd2: rgb_next = '{red: mval, green: chroma, blue: xval};
      3'd3: rgb_next = '{red: mval, green: xval, blue: chroma};
      3'd4: rgb_next = '{red: xval, green: mval, blue: chroma};
      default: rgb_next = '{red: chroma, green: mval, blue: xval};  // also full hue
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (adv1) v1 <= hsv_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) rgb_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      sext <= mx.sext;
      chroma <= mx.chroma;
    end
    if (adv4) begin
      rgb <= rgb_next;
    end
  end

endmodule

[sv/hsv2rgb_chk.sv]
module hsv2rgb_chk
  import hsv2rgb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       hsv_valid,
  input logic       hsv_stall,
  input hsv_pixel_t hsv,
  input logic       rgb_valid,
  input logic       rgb_stall,
  input rgb_pixel_t rgb
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
    else $error("rgb changed while stalled");

  // input only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> rgb_valid && rgb_stall)
    else $error("hsv_stall without a blocked output");

  // zero brightness gives black when the output is not stalled on the way
  a_black: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall && hsv.brightness == 8'd0)
      ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
    |=> rgb_valid && rgb.red == 8'd0 && rgb.green == 8'd0 && rgb.blue == 8'd0)
    else $error("black pixel expected");

  // pure red at hue zero, full saturation and brightness
  a_red: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && !hsv_stall && hsv.hue == 8'd0 && hsv.saturation == 8'd255
      && hsv.brightness == 8'd255)
      ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
    |=> rgb_valid && rgb.red == 8'd255 && rgb.green == 8'd0 && rgb.blue == 8'd0)
    else $error("pure red expected");

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .hsv_valid (hsv_valid),
  .hsv_stall (hsv_stall),
  .hsv       (hsv),
  .rgb_valid (rgb_valid),
  .rgb_stall (rgb_stall),
  .rgb       (rgb)
);

[tb/hsv_to_rgb_converter_unit_tb.sv]
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit_tb;
  import hsv2rgb_pkg::*;

  localparam int unsigned SCALE = 255;
  localparam int unsigned DENOM = SCALE * SCALE;
  localparam int RAND_PER_PHASE = 420;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_DIRECTED = 22;

  typedef struct {
    hsv_pixel_t px;
    bit         known;
    rgb_pixel_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       hsv_valid = 1'b0;
  logic       hsv_stall;
  hsv_pixel_t hsv = '0;
  logic       rgb_valid;
  logic       rgb_stall = 1'b0;
  rgb_pixel_t rgb;

  rgb_pixel_t pending_rgb[$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  stim_row_t  directed [NUM_DIRECTED];

  hsv_to_rgb_converter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hsv       (hsv),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // N is the channel scaled by 65025; round half up, clamp at full scale
  function automatic logic [CH_W-1:0] round_level(int unsigned n);
    int unsigned lvl;
    lvl = (2 * n + DENOM) / (2 * DENOM);
    return (lvl > SCALE) ? CH_W'(SCALE) : CH_W'(lvl);
  endfunction

  function automatic rgb_pixel_t hsv_to_rgb(hsv_pixel_t px);
    int unsigned h, s, v, sext, rem, k, offs, peak, mix;
    rgb_pixel_t  o;
    h = px.hue;
    s = px.saturation;
    v = px.brightness;
    sext = (6 * h) / SCALE;
    rem  = (6 * h) % SCALE;
    k    = (sext % 2 == 1) ? SCALE - rem : rem;
    offs = v * (SCALE - s) * SCALE;
    peak = v * s * SCALE + offs;
    mix  = v * s * k + offs;
    // hue 255 lands in sextant six and reuses the sextant five pattern
    case (sext)
      0: begin
        o.red = round_level(peak); o.green = round_level(mix); o.blue = round_level(offs);
      end
      1: begin
        o.red = round_level(mix); o.green = round_level(peak); o.blue = round_level(offs);
      end
      2: begin
        o.red = round_level(offs); o.green = round_level(peak); o.blue = round_level(mix);
      end
      3: begin
        o.red = round_level(offs); o.green = round_level(mix); o.blue = round_level(peak);
      end
      4: begin
        o.red = round_level(mix); o.green = round_level(offs); o.blue = round_level(peak);
      end
      default: begin
        o.red = round_level(peak); o.green = round_level(offs); o.blue = round_level(mix);
      end
    endcase
    return o;
  endfunction

  task automatic send_pixel(hsv_pixel_t px, bit known, rgb_pixel_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      hsv_valid <= 1'b0;
      hsv <= 24'($urandom);
      @(posedge clk);
    end
    hsv <= px;
    hsv_valid <= 1'b1;
    do @(posedge clk); while (hsv_stall);
    pending_rgb.insert(pending_rgb.size(), known ? want : hsv_to_rgb(px));
  endtask

  task automatic wait_drained();
    hsv_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rgb_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    rgb_pixel_t exp_px;
    if (!rst && rgb_valid && !rgb_stall) begin
      if (pending_rgb.size() == 0) begin
        $error("unexpected rgb transfer: red=%0d green=%0d blue=%0d",
               rgb.red, rgb.green, rgb.blue);
        mismatches++;
      end else begin
        exp_px = pending_rgb.pop_front();
        if (rgb.red !== exp_px.red) begin
          $error("red: expected %0d, got %0d", exp_px.red, rgb.red);
          mismatches++;
        end
        if (rgb.green !== exp_px.green) begin
          $error("green: expected %0d, got %0d", exp_px.green, rgb.green);
          mismatches++;
        end
        if (rgb.blue !== exp_px.blue) begin
          $error("blue: expected %0d, got %0d", exp_px.blue, rgb.blue);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (hsv_valid && !hsv_stall) || (rgb_valid && !rgb_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    hsv_pixel_t px;
    int         e;
    int         sv_edges [4];

    sv_edges = '{0, 1, 254, 255};
    directed = '{
      '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
      '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
      '{'{8'd85,  8'd255, 8'd255}, 1'b1, '{8'd0,   8'd255, 8'd0  }},
      '{'{8'd170, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd255}},
      '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{'{8'd123, 8'd0,   8'd200}, 1'b1, '{8'd200, 8'd200, 8'd200}},
      '{'{8'd77,  8'd255, 8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd42,  8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd43,  8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd100, 8'd200, 8'd180}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd150, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd190, 8'd128, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd230, 8'd255, 8'd128}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd254, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd1,   8'd1,   8'd1  }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd128, 8'd127, 8'd254}, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd170, 8'd170, 8'd85 }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'h55,  8'hAA,  8'h55 }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'hAA,  8'h55,  8'hAA }, 1'b0, '{8'd0,   8'd0,   8'd0  }},
      '{'{8'd20,  8'd255, 8'd1  }, 1'b0, '{8'd0,   8'd0,   8'd0  }}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_pixel(directed[i].px, directed[i].known, directed[i].want);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        px = 24'($urandom);
        case ($urandom_range(3))
          0: begin
            // hue right around a sextant boundary
            e = ($urandom_range(6) * SCALE + 5) / 6 + $urandom_range(2) - 1;
            px.hue = (e < 0) ? 8'd0 : (e > 255) ? 8'd255 : 8'(e);
          end
          1: begin
            px.saturation = 8'(sv_edges[$urandom_range(3)]);
            px.brightness = 8'(sv_edges[$urandom_range(3)]);
          end
          2: px.hue = $urandom_range(1) ? 8'd255 : 8'd0;
          default: ;
        endcase
        send_pixel(px, 1'b0, '0);
      end
      // hold the sender off until the pipe has fully emptied
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rgb.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
